FILE: design/tmq_pkg.sv
package tmq_pkg;

	localparam int DepthDefault = 16;

	localparam logic [2:0] MODE_ENQ      = 3'd0;
	localparam logic [2:0] MODE_DEQ      = 3'd1;
	localparam logic [2:0] MODE_RM_WHAT  = 3'd2;
	localparam logic [2:0] MODE_RM_CB    = 3'd3;
	localparam logic [2:0] MODE_RM_HNDL  = 3'd4;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LOCKED   = 3'd1,
		ST_FULL     = 3'd2,
		ST_NULL_KEY = 3'd3,
		ST_NOT_DUE  = 3'd4,
		ST_EMPTY    = 3'd5,
		ST_NO_MATCH = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_REM_RD,
		S_REM_WR,
		S_DQ_RD,
		S_DQ_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [7:0]         handler_id;
		logic signed [31:0] what_code;
		logic [7:0]         callback_id;
		logic [7:0]         message_tag;
		logic [63:0]        time_value;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         popped_handler;
		logic signed [31:0] popped_what;
		logic [7:0]         popped_callback;
		logic [7:0]         popped_tag;
		logic [63:0]        popped_time;
		logic [63:0]        head_due_time;
		logic               queue_empty;
		logic [4:0]         entry_count;
	} out_beat_t;

	typedef struct packed {
		logic [63:0]        due;
		logic [7:0]         handler;
		logic signed [31:0] what;
		logic [7:0]         callback;
		logic [7:0]         tag;
	} rec_t;

endpackage

FILE: design/tmq_chan.sv
interface tmq_chan #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/timed_message_queue_top.sv
// Time-ordered message queue of DEPTH entries held in one single-port record
// memory used as a ring (head pointer plus count). One beat in, one result beat
// out. Refused and null-key requests go straight to the result; a sorted insert
// shifts each entry due later than the new one up by one slot, or every queued
// entry when it goes to the front; a removal reads every queued entry and writes
// back those that stay. Each step is a read and then a write over the single
// memory port.
// No new beat is taken until the previous result has entered the output register.
module timed_message_queue_top #(
	parameter int DEPTH = tmq_pkg::DepthDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	tmq_chan.sink    in_ch,
	tmq_chan.source  out_ch
);
	import tmq_pkg::*;

	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	state_t              state_q, state_d;
	logic [IdxW-1:0]     head_q;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     idx_q;
	logic [CntW-1:0]     wr_q;
	logic                locked_q;
	logic                front_q;
	logic                found_q;
	rec_t                head_rec_q;
	rec_t                pop_q;
	in_beat_t            req_q;
	status_t             status_q;
	logic                out_valid_q;
	out_beat_t           out_q;

	logic [IdxW-1:0]     mem_addr;
	logic                mem_we;
	rec_t                mem_wdata;
	rec_t                mem_rdata;
	rec_t                new_rec;
	logic                accept;
	logic                out_free;
	logic                ins_move;
	logic                rem_hit;

	function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] hd,
			input logic [CntW-1:0] l);
		logic [CntW:0] s;
		s = (CntW+1)'(hd) + (CntW+1)'(l);
		if (s >= (CntW+1)'(DEPTH)) begin
			s = s - (CntW+1)'(DEPTH);
		end
		return s[IdxW-1:0];
	endfunction

	tmq_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_free     = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	assign new_rec.due      = req_q.time_value;
	assign new_rec.handler  = req_q.handler_id;
	assign new_rec.what     = req_q.what_code;
	assign new_rec.callback = req_q.callback_id;
	assign new_rec.tag      = req_q.message_tag;

	assign ins_move = front_q || (mem_rdata.due > req_q.time_value);

	always_comb begin
		rem_hit = (mem_rdata.handler == req_q.handler_id);
		case (req_q.mode)
			MODE_RM_WHAT: rem_hit = rem_hit && (mem_rdata.what == req_q.what_code);
			MODE_RM_CB:   rem_hit = rem_hit && (mem_rdata.callback == req_q.callback_id);
			default:      rem_hit = rem_hit;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_ch.data.mode)
						MODE_ENQ: begin
							if (locked_q || count_q == CntW'(DEPTH)) begin
								state_d = S_FIN;
							end else begin
								state_d = S_INS_RD;
							end
						end
						MODE_DEQ: begin
							if (count_q != '0 && in_ch.data.time_value >= head_rec_q.due
									&& count_q != CntW'(1)) begin
								state_d = S_DQ_RD;
							end else begin
								state_d = S_FIN;
							end
						end
						MODE_RM_WHAT, MODE_RM_CB, MODE_RM_HNDL: begin
							if (in_ch.data.handler_id == '0 || (in_ch.data.mode == MODE_RM_CB
									&& in_ch.data.callback_id == '0)) begin
								state_d = S_FIN;
							end else begin
								state_d = S_REM_RD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_INS_RD: state_d = (idx_q == '0) ? S_FIN : S_INS_WR;
			S_INS_WR: state_d = ins_move ? S_INS_RD : S_FIN;
			S_REM_RD: state_d = (idx_q == count_q) ? S_FIN : S_REM_WR;
			S_REM_WR: state_d = S_REM_RD;
			S_DQ_RD:  state_d = S_DQ_WR;
			S_DQ_WR:  state_d = S_FIN;
			S_FIN:    state_d = out_free ? S_IDLE : S_FIN;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port
	always_comb begin
		mem_addr  = head_q;
		mem_we    = 1'b0;
		mem_wdata = new_rec;
		case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					mem_addr = phys(head_q, '0);
					mem_we   = 1'b1;
				end else begin
					mem_addr = phys(head_q, idx_q - CntW'(1));
				end
			end
			S_INS_WR: begin
				mem_addr = phys(head_q, idx_q);
				mem_we   = 1'b1;
				if (ins_move) begin
					mem_wdata = mem_rdata;
				end
			end
			S_REM_RD: mem_addr = phys(head_q, idx_q);
			S_REM_WR: begin
				mem_addr  = phys(head_q, wr_q);
				mem_we    = !rem_hit;
				mem_wdata = mem_rdata;
			end
			S_DQ_RD:  mem_addr = head_q;
			default:  mem_addr = head_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			locked_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= in_ch.data;
						pop_q    <= '0;
						status_q <= ST_OK;
						idx_q    <= '0;
						wr_q     <= '0;
						found_q  <= 1'b0;
						case (in_ch.data.mode)
							MODE_ENQ: begin
								if (locked_q) begin
									status_q <= ST_LOCKED;
								end else if (count_q == CntW'(DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									if (in_ch.data.handler_id == '0) begin
										locked_q <= 1'b1;
									end
									idx_q   <= count_q;
									front_q <= (count_q == '0) || (in_ch.data.time_value == '0)
										|| (in_ch.data.time_value < head_rec_q.due);
								end
							end
							MODE_DEQ: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (in_ch.data.time_value >= head_rec_q.due) begin
									pop_q   <= head_rec_q;
									head_q  <= phys(head_q, CntW'(1));
									count_q <= count_q - CntW'(1);
								end else begin
									status_q <= ST_NOT_DUE;
								end
							end
							MODE_RM_WHAT, MODE_RM_CB, MODE_RM_HNDL: begin
								if (in_ch.data.handler_id == '0 || (in_ch.data.mode == MODE_RM_CB
										&& in_ch.data.callback_id == '0)) begin
									status_q <= ST_NULL_KEY;
								end
							end
							default: status_q <= ST_OK;
						endcase
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						head_rec_q <= new_rec;
						count_q    <= count_q + CntW'(1);
					end
				end
				S_INS_WR: begin
					if (ins_move) begin
						idx_q <= idx_q - CntW'(1);
					end else begin
						count_q <= count_q + CntW'(1);
					end
				end
				S_REM_RD: begin
					if (idx_q == count_q) begin
						count_q  <= wr_q;
						status_q <= found_q ? ST_OK : ST_NO_MATCH;
					end
				end
				S_REM_WR: begin
					idx_q <= idx_q + CntW'(1);
					if (rem_hit) begin
						found_q <= 1'b1;
					end else begin
						if (wr_q == '0) begin
							head_rec_q <= mem_rdata;
						end
						wr_q <= wr_q + CntW'(1);
					end
				end
				S_DQ_WR: head_rec_q <= mem_rdata;
				S_FIN: begin
					if (out_free) begin
						out_q.status          <= status_q;
						out_q.popped_handler  <= pop_q.handler;
						out_q.popped_what     <= pop_q.what;
						out_q.popped_callback <= pop_q.callback;
						out_q.popped_tag      <= pop_q.tag;
						out_q.popped_time     <= pop_q.due;
						out_q.head_due_time   <= (count_q != '0) ? head_rec_q.due : '0;
						out_q.queue_empty     <= (count_q == '0);
						out_q.entry_count     <= 5'(count_q);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: design/tmq_store.sv
module tmq_store #(
	parameter int DEPTH = tmq_pkg::DepthDefault,
	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic [IdxW-1:0]     addr,
	input  logic                we,
	input  tmq_pkg::rec_t       wdata,
	output tmq_pkg::rec_t       rdata
);
	import tmq_pkg::*;

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: design/tmq_checker.sv
module tmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  popped_handler,
	input logic [63:0] popped_time,
	input logic [63:0] head_due_time,
	input logic        queue_empty,
	input logic [4:0]  entry_count
);
	import tmq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result beat dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

	a_no_pop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> popped_handler == '0 && popped_time == '0)
		else $error("pop fields set without a pop");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |-> head_due_time == '0 && entry_count == '0)
		else $error("empty queue reports a head");

	a_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count != '0 |-> !queue_empty)
		else $error("count and empty flag disagree");
endmodule

bind timed_message_queue_top tmq_checker u_tmq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.status         (out_ch.data.status),
	.popped_handler (out_ch.data.popped_handler),
	.popped_time    (out_ch.data.popped_time),
	.head_due_time  (out_ch.data.head_due_time),
	.queue_empty    (out_ch.data.queue_empty),
	.entry_count    (out_ch.data.entry_count)
);
